// File: rtl/core/pusrt_pkg.sv
package pusrt_pkg;

    localparam int DATA_W = 32;

    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // source of the memory write data
    typedef enum logic [1:0] {
        WSRC_ZERO = 2'd0,
        WSRC_CUR  = 2'd1,
        WSRC_SUM  = 2'd2
    } wsrc_t;

    // controller to datapath, aligned with the memory read data
    typedef struct packed {
        logic  wr_en;
        wsrc_t wr_sel;
        logic  add_a;
        logic  add_b;
        logic  fire;
    } ctl_t;

endpackage

// File: rtl/core/pusrt_ram.sv
module pusrt_ram #(
    parameter int AW = 11
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [pusrt_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]                raddr_a,
    input  logic [AW-1:0]                raddr_b,
    output logic [pusrt_pkg::DATA_W-1:0] rdata_a,
    output logic [pusrt_pkg::DATA_W-1:0] rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [pusrt_pkg::DATA_W-1:0] mem [DEPTH];
    logic [pusrt_pkg::DATA_W-1:0] rdata_a_reg;
    logic [pusrt_pkg::DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: rtl/core/pusrt_ctrl.sv
module pusrt_ctrl #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          command,
    input  logic [$clog2(LEAF_COUNT)-1:0] position,
    input  logic [$clog2(LEAF_COUNT):0]   range_low,
    input  logic [$clog2(LEAF_COUNT):0]   range_high,
    output logic                          busy,
    output pusrt_pkg::ctl_t               ctl,
    output logic [$clog2(LEAF_COUNT):0]   waddr,
    output logic [$clog2(LEAF_COUNT):0]   raddr_a,
    output logic [$clog2(LEAF_COUNT):0]   raddr_b
);

    localparam int LW = $clog2(LEAF_COUNT);
    localparam int AW = LW + 1;
    localparam int IW = LW + 2;

    typedef enum logic [4:0] {
        ST_CLEAR    = 5'b00001,
        ST_IDLE     = 5'b00010,
        ST_SET_LEAF = 5'b00100,
        ST_SET_UP   = 5'b01000,
        ST_QUERY    = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;
    logic [AW-1:0] node_reg, node_next;
    logic [IW-1:0] lo_reg, lo_next;
    logic [IW-1:0] hi_reg, hi_next;
    logic          pend_a_reg, pend_a_next;
    logic          pend_b_reg, pend_b_next;

    logic          accept;
    logic [AW-1:0] hi_clip;
    logic          empty;
    logic [AW-1:0] parent;
    logic [IW-1:0] lo_inc;
    logic [IW-1:0] hi_dec;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign hi_clip = (range_high > AW'(LEAF_COUNT)) ? AW'(LEAF_COUNT) : range_high;
    assign empty   = (range_low >= hi_clip);
    assign parent  = node_reg >> 1;
    assign lo_inc  = lo_reg + IW'(lo_reg[0]);
    assign hi_dec  = hi_reg - IW'(1);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        node_next    = node_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pend_a_next  = 1'b0;
        pend_b_next  = 1'b0;
        ctl.wr_en    = 1'b0;
        ctl.wr_sel   = pusrt_pkg::WSRC_ZERO;
        ctl.add_a    = pend_a_reg;
        ctl.add_b    = pend_b_reg;
        ctl.fire     = 1'b0;
        waddr        = node_reg;
        raddr_a      = node_reg ^ AW'(1);
        raddr_b      = hi_dec[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.wr_en    = 1'b1;
                waddr        = clr_idx_reg;
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == pusrt_pkg::CMD_SET)
                    begin
                        node_next  = {1'b1, position};
                        state_next = ST_SET_LEAF;
                    end
                    else
                    begin
                        lo_next    = empty ? '0 : IW'(range_low) + IW'(LEAF_COUNT);
                        hi_next    = empty ? '0 : IW'(hi_clip) + IW'(LEAF_COUNT);
                        state_next = ST_QUERY;
                    end
                end
            end
            ST_SET_LEAF:
            begin
                // leaf write, sibling read issued in the same cycle
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = pusrt_pkg::WSRC_CUR;
                state_next = ST_SET_UP;
            end
            ST_SET_UP:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = pusrt_pkg::WSRC_SUM;
                waddr      = parent;
                raddr_a    = parent ^ AW'(1);
                node_next  = parent;
                if (parent == AW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QUERY:
            begin
                if (lo_reg < hi_reg)
                begin
                    raddr_a     = lo_reg[AW-1:0];
                    pend_a_next = lo_reg[0];
                    pend_b_next = hi_reg[0];
                    lo_next     = lo_inc >> 1;
                    hi_next     = hi_reg >> 1;
                end
                else
                begin
                    // last level's reads land now, fold them into the result
                    ctl.fire   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            node_reg    <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            pend_a_reg  <= 1'b0;
            pend_b_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            node_reg    <= node_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            pend_a_reg  <= pend_a_next;
            pend_b_reg  <= pend_b_next;
        end
    end

endmodule

// File: rtl/core/point_update_range_sum_tree_top.sv
// channel   signals                                                      direction
// command   start busy command position new_value range_low range_high   in
// result    done range_sum                                               out
//
// reset starts a clearing pass over every node, one node a cycle: busy stays high
// through it and drops before the first command transfer
// a set keeps busy high through a leaf write, then one read-add-write per
// ancestor through the memory's write port
// a query keeps busy high while it walks the tree, one tree level per cycle, and
// through a final fold; done follows next cycle and cannot be held off
module point_update_range_sum_tree_top #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic [$clog2(LEAF_COUNT)-1:0]        position,
    input  logic signed [pusrt_pkg::DATA_W-1:0]  new_value,
    input  logic [$clog2(LEAF_COUNT):0]          range_low,
    input  logic [$clog2(LEAF_COUNT):0]          range_high,
    output logic                                 done,
    output logic signed [pusrt_pkg::DATA_W-1:0] range_sum
);

    localparam int AW = $clog2(LEAF_COUNT) + 1;
    localparam int DW = pusrt_pkg::DATA_W;

    pusrt_pkg::ctl_t ctl;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    logic [DW-1:0]   rdata_a;
    logic [DW-1:0]   rdata_b;
    logic [DW-1:0]   wdata;

    logic [DW-1:0]        cur_reg, cur_next;
    logic [DW-1:0]        acc_reg, acc_next;
    logic signed [DW-1:0] range_sum_reg;
    logic                 done_reg;

    logic          accept;
    logic [DW-1:0] set_sum;
    logic [DW-1:0] term_a;
    logic [DW-1:0] term_b;
    logic [DW-1:0] acc_sum;

    pusrt_ctrl #(
        .LEAF_COUNT(LEAF_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .position  (position),
        .range_low (range_low),
        .range_high(range_high),
        .busy      (busy),
        .ctl       (ctl),
        .waddr     (waddr),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b)
    );

    pusrt_ram #(
        .AW(AW)
    ) u_ram (
        .clk    (clk),
        .we     (ctl.wr_en),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    assign accept  = start && !busy;
    assign set_sum = cur_reg + rdata_a;
    assign term_a  = ctl.add_a ? rdata_a : '0;
    assign term_b  = ctl.add_b ? rdata_b : '0;
    assign acc_sum = acc_reg + term_a + term_b;

    always_comb
    begin
        unique case (ctl.wr_sel)
            pusrt_pkg::WSRC_ZERO: wdata = '0;
            pusrt_pkg::WSRC_CUR:  wdata = cur_reg;
            pusrt_pkg::WSRC_SUM:  wdata = set_sum;
            default:              wdata = '0;
        endcase
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (accept)
        begin
            cur_next = new_value;
        end
        else if (ctl.wr_en && (ctl.wr_sel == pusrt_pkg::WSRC_SUM))
        begin
            cur_next = set_sum;
        end
        acc_next = accept ? '0 : acc_sum;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        acc_reg <= acc_next;
        if (ctl.fire)
        begin
            range_sum_reg <= acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.fire;
        end
    end

    assign done      = done_reg;
    assign range_sum = range_sum_reg;

    // a result always comes with the block back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // a taken command keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("command transfer did not start work");

    // the leaf write of a set transfer is not followed by a result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == pusrt_pkg::CMD_SET)) |=> ##1 !done)
        else $error("result after set command");

    // node 0 is unused, only the clearing pass may touch it
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_en && (ctl.wr_sel != pusrt_pkg::WSRC_ZERO)) |-> (waddr != '0))
        else $error("tree write to unused node");

endmodule

// File: tb/point_update_range_sum_tree_checker.sv
module point_update_range_sum_tree_checker #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 command,
    input  logic [$clog2(LEAF_COUNT)-1:0]        position,
    input  logic signed [pusrt_pkg::DATA_W-1:0]  new_value,
    input  logic [$clog2(LEAF_COUNT):0]          range_low,
    input  logic [$clog2(LEAF_COUNT):0]          range_high,
    input  logic                                 done,
    input  logic signed [pusrt_pkg::DATA_W-1:0]  range_sum,
    output int                                   mismatches,
    output int                                   pending_sums
);

    logic [pusrt_pkg::DATA_W-1:0] leaf_vals [LEAF_COUNT];
    logic [pusrt_pkg::DATA_W-1:0] sum_queue [$];
    int                           mismatch_count = 0;
    int                           query_count = 0;

    assign mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // plain leaf walk, independent of how the block orders its tree reads
    function automatic logic [pusrt_pkg::DATA_W-1:0] range_total(input int lo, input int hi);
        logic [pusrt_pkg::DATA_W-1:0] acc;
        acc = '0;
        if (hi > LEAF_COUNT)
            hi = LEAF_COUNT;
        for (int i = lo; i < hi; i++)
            acc += leaf_vals[i];
        return acc;
    endfunction

    always @(posedge clk)
    begin
        logic [pusrt_pkg::DATA_W-1:0] want;
        if (!rst_n)
        begin
            foreach (leaf_vals[i])
                leaf_vals[i] = '0;
            sum_queue.delete();
        end
        else
        begin
            // result side first: a new query can never complete at its own transfer
            if (done !== 1'b0)
            begin
                if (done !== 1'b1)
                    report_mismatch("done strobe is unknown");
                else if (sum_queue.size() == 0)
                    report_mismatch($sformatf("range_sum %h with no query waiting",
                                              range_sum));
                else
                begin
                    want = sum_queue.pop_front();
                    query_count++;
                    if (range_sum !== want)
                        report_mismatch($sformatf("query %0d: range_sum %h, want %h",
                                                  query_count, range_sum, want));
                end
            end
            if (start && !busy)
            begin
                if (command == pusrt_pkg::CMD_SET)
                    leaf_vals[position] = new_value;
                else
                    sum_queue.push_back(range_total(int'(range_low), int'(range_high)));
            end
        end
        pending_sums <= sum_queue.size();
    end

endmodule

// File: tb/point_update_range_sum_tree_top_test.sv
module point_update_range_sum_tree_top_test;

    localparam int LEAF_COUNT   = 1024;
    localparam int POS_W        = $clog2(LEAF_COUNT);
    localparam int RANGE_W      = POS_W + 1;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                start      = 1'b0;
    logic                                command    = pusrt_pkg::CMD_SET;
    logic [POS_W-1:0]                    position   = '0;
    logic signed [pusrt_pkg::DATA_W-1:0] new_value  = '0;
    logic [POS_W:0]                      range_low  = '0;
    logic [POS_W:0]                      range_high = '0;
    logic                                busy;
    logic                                done;
    logic signed [pusrt_pkg::DATA_W-1:0] range_sum;
    int                                  mismatches;
    int                                  pending_sums;
    int                                  cycle_count  = 0;
    int                                  no_idle_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    point_update_range_sum_tree_top #(
        .LEAF_COUNT(LEAF_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .position  (position),
        .new_value (new_value),
        .range_low (range_low),
        .range_high(range_high),
        .done      (done),
        .range_sum (range_sum)
    );

    point_update_range_sum_tree_checker #(
        .LEAF_COUNT(LEAF_COUNT)
    ) sum_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .position    (position),
        .new_value   (new_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .done        (done),
        .range_sum   (range_sum),
        .mismatches  (mismatches),
        .pending_sums(pending_sums)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one command transfer, after a random gap or none in a burst; returns once busy reads low
    task automatic issue(input logic cmd, input logic [POS_W-1:0] pos,
                         input logic [pusrt_pkg::DATA_W-1:0] val,
                         input logic [POS_W:0] lo, input logic [POS_W:0] hi);
        int gap;
        if (no_idle_left > 0)
        begin
            gap = 0;
            no_idle_left--;
        end
        else
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
                no_idle_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        position   <= pos;
        new_value  <= val;
        range_low  <= lo;
        range_high <= hi;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // unused fields carry random noise
    task automatic set_leaf(input int pos, input logic [pusrt_pkg::DATA_W-1:0] val);
        issue(pusrt_pkg::CMD_SET, POS_W'(pos), val,
              RANGE_W'($urandom_range(0, LEAF_COUNT)),
              RANGE_W'($urandom_range(0, LEAF_COUNT)));
    endtask

    task automatic query(input int lo, input int hi);
        issue(pusrt_pkg::CMD_QUERY, POS_W'($urandom_range(0, LEAF_COUNT - 1)), $urandom,
              RANGE_W'(lo), RANGE_W'(hi));
    endtask

    initial
    begin
        int                           hot_base;
        int                           pick;
        int                           a;
        int                           b;
        logic [pusrt_pkg::DATA_W-1:0] val;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty tree, extreme values at both ends, wrapping sums
        query(0, LEAF_COUNT);
        set_leaf(0, 32'h7fff_ffff);
        set_leaf(LEAF_COUNT - 1, 32'h8000_0000);
        set_leaf(1, 32'h7fff_ffff);
        query(0, LEAF_COUNT);
        query(0, 1);
        query(LEAF_COUNT - 1, LEAF_COUNT);
        query(0, 2);
        query(5, 5);
        query(700, 3);
        query(LEAF_COUNT, LEAF_COUNT);
        query(LEAF_COUNT, 0);
        query(1, LEAF_COUNT - 1);
        query(0, LEAF_COUNT - 1);
        set_leaf(LEAF_COUNT / 2, 32'hffff_ffff);
        set_leaf(0, 32'h0000_0000);
        query(0, LEAF_COUNT);
        query(LEAF_COUNT / 2 - 1, LEAF_COUNT / 2 + 1);

        // random: sets and queries, often around a small hot window
        hot_base = $urandom_range(0, LEAF_COUNT - 32);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                hot_base = $urandom_range(0, LEAF_COUNT - 32);
            if ($urandom_range(0, 99) < 50)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    val = 32'h7fff_ffff;
                else if (pick < 8)
                    val = 32'h8000_0000;
                else if (pick < 11)
                    val = 32'hffff_ffff;
                else if (pick < 13)
                    val = '0;
                else
                    val = $urandom;
                if ($urandom_range(0, 99) < 40)
                    set_leaf(hot_base + $urandom_range(0, 31), val);
                else
                    set_leaf($urandom_range(0, LEAF_COUNT - 1), val);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    query(0, LEAF_COUNT);
                else if (pick < 18)
                begin
                    a = $urandom_range(0, LEAF_COUNT);
                    query(a, a);
                end
                else if (pick < 26)
                begin
                    a = $urandom_range(1, LEAF_COUNT);
                    query(a, $urandom_range(0, a - 1));
                end
                else if (pick < 31)
                    query(LEAF_COUNT, $urandom_range(0, LEAF_COUNT));
                else if (pick < 65)
                begin
                    a = $urandom_range(0, LEAF_COUNT);
                    b = $urandom_range(0, LEAF_COUNT);
                    if (a <= b)
                        query(a, b);
                    else
                        query(b, a);
                end
                else
                begin
                    a = hot_base + $urandom_range(0, 16);
                    query(a, a + $urandom_range(1, 16));
                end
            end
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending_sums != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
